// ===== design/sfpd_pkg.sv =====
// Shared types and constants of the sensor frame peak decoder.
package sfpd_pkg;

    localparam int unsigned POS_W = 13;

    localparam logic [POS_W-1:0] POS_STATION_LO = 13'd4;
    localparam logic [POS_W-1:0] POS_STATION_HI = 13'd5;
    localparam logic [POS_W-1:0] POS_SAMPLE_FIRST = 13'd8;
    localparam logic [POS_W-1:0] POS_SAMPLE_LAST = 13'd4085;
    localparam logic [POS_W-1:0] POS_DATE_FIRST = 13'd4086;
    localparam logic [POS_W-1:0] POS_DATE_LAST = 13'd4091;
    localparam logic [POS_W-1:0] POS_COUNT_LO = 13'd4092;
    localparam logic [POS_W-1:0] POS_COUNT_MID = 13'd4093;
    localparam logic [POS_W-1:0] POS_SUMMARY = 13'd4094;

    localparam logic [1:0] LANE_LOW_BYTE = 2'd0;
    localparam logic [1:0] LANE_HIGH_BYTE = 2'd1;

    localparam logic [15:0] RAW_MAX = 16'd4095;
    localparam logic signed [12:0] CENTRE = 13'sd2047;
    localparam logic [11:0] YEAR_BASE = 12'd2000;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic CFG_CLIP_THRESHOLD = 1'b0;
    localparam logic CFG_PRETRIGGER = 1'b1;

    localparam logic signed [11:0] CLIP_RESET = -12'sd1638;
    localparam logic [9:0] PRETRIGGER_RESET = 10'd120;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] data_byte;
    } sfpd_item_t;

    typedef struct packed {
        logic signed [11:0] clip_threshold;
        logic [9:0]         pretrigger_samples;
    } sfpd_cfg_t;

    // Packed from the top down, so sample_index lands in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic [9:0]         peak_index;
        logic signed [25:0] microsecond;
        logic [9:0]         station_id;
        logic [7:0]         second;
        logic [7:0]         minute;
        logic [7:0]         hour;
        logic [7:0]         day;
        logic [7:0]         month;
        logic [11:0]        year;
        logic signed [12:0] sample_value;
        logic [9:0]         sample_index;
    } sfpd_result_t;

    typedef struct packed {
        logic       kind;
        sfpd_result_t data;
    } sfpd_out_t;

endpackage

// ===== design/sensor_frame_peak_decoder.sv =====
// Top level of the sensor frame peak decoder with its configuration registers.
//
// Each request on the s_ channel carries one frame byte in s_tdata, and s_tuser
// set to one marks byte zero of a frame. Bytes 4 and 5 give the station id,
// samples sit at bytes 8+4k and 9+4k, and the date, time and microsecond
// count follow at bytes 4086 to 4094.
// A sample result (m_tuser zero) is produced for the high byte of every
// sample below NUM_SAMPLES; a summary result (m_tuser one) for byte 4094.
// All other bytes are absorbed without a result.
// A result reaches m_tvalid through the input register and then the result
// register, and one byte can be accepted in every cycle while m_tready is high:
// the decode logic sits between the two registers and keeps up with the byte rate.
// When m_tready is low the result register holds and the input register
// keeps one more byte; s_tready drops only once both are full.
// The synchronous active-low reset empties both registers, clears all frame
// state and loads the default clip threshold and pretrigger count. Until the
// first frame mark, the first byte after reset is taken as byte zero.
// Configuration writes take effect at the clock edge where cfg_we is high.
module sensor_frame_peak_decoder
    import sfpd_pkg::*;
#(
    parameter int unsigned NUM_SAMPLES = 1020
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [11:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_index, sample_value, year, month, day, hour, minute, second,
    // station_id, microsecond, peak_index, then zero fill
    output logic [127:0] m_tdata,
    output logic         m_tuser    // kind
);

    sfpd_cfg_t  cfg_reg;
    sfpd_item_t s_item;
    sfpd_item_t q_item;
    sfpd_out_t  m_out;
    logic       q_valid;
    logic       advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_threshold <= CLIP_RESET;
            cfg_reg.pretrigger_samples <= PRETRIGGER_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CLIP_THRESHOLD: cfg_reg.clip_threshold <= cfg_wdata;
                CFG_PRETRIGGER: cfg_reg.pretrigger_samples <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign s_item.data_byte = s_tdata;
    assign s_item.frame_start = s_tuser;

    sfpd_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .advance (advance),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    sfpd_decode #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (q_valid),
        .in_item  (q_item),
        .advance  (advance),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_out    (m_out)
    );

    assign m_tdata = m_out.data;
    assign m_tuser = m_out.kind;

    sfpd_result_t res_view;
    assign res_view = sfpd_result_t'(m_tdata);

    // The input side only stalls while a finished result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SUMMARY)) |->
        (res_view.sample_index == '0 && res_view.sample_value == '0))
        else $error("summary result carries sample fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SAMPLE)) |->
        (res_view.year == '0 && res_view.microsecond == '0
         && res_view.peak_index == '0 && res_view.station_id == '0))
        else $error("sample result carries summary fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SAMPLE)) |->
        ({1'b0, res_view.sample_index} < 11'(NUM_SAMPLES)))
        else $error("sample index beyond the sample count");

endmodule

// ===== design/sfpd_in_reg.sv =====
// Input register stage of the sensor frame peak decoder.
module sfpd_in_reg
    import sfpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sfpd_item_t s_item,
    input  logic       advance,
    output logic       q_valid,
    output sfpd_item_t q_item
);

    logic       valid_reg;
    sfpd_item_t item_reg;

    assign s_ready = !valid_reg || advance;
    assign q_valid = valid_reg;
    assign q_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== design/sfpd_decode.sv =====
// Frame decoding, peak and minimum tracking, and the result register.
module sfpd_decode
    import sfpd_pkg::*;
#(
    parameter int unsigned NUM_SAMPLES = 1020
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  sfpd_cfg_t  cfg,
    input  logic       in_valid,
    input  sfpd_item_t in_item,
    output logic       advance,
    output logic       m_valid,
    input  logic       m_ready,
    output sfpd_out_t  m_out
);

    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         low_byte_reg;
    logic signed [12:0] max_level_reg;
    logic [9:0]         max_pos_reg;
    logic signed [12:0] min_level_reg;
    logic [7:0]         date_reg [6];
    logic [9:0]         station_reg;
    logic [15:0]        count_reg;
    logic               out_valid_reg;
    sfpd_out_t          out_reg;

    logic               work;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   date_off;
    logic               in_samples;
    logic               is_low;
    logic               is_high;
    logic [9:0]         k;
    logic [15:0]        raw;
    logic [11:0]        raw_sat;
    logic signed [12:0] v;
    logic signed [12:0] clip_ext;
    logic               new_max;
    logic               new_min;
    logic signed [10:0] delta;
    logic signed [25:0] delta_ext;
    logic [23:0]        us;
    logic               emit;
    sfpd_out_t          res;

    assign advance = !out_valid_reg || m_ready;
    assign work = in_valid && advance;
    assign m_valid = out_valid_reg;
    assign m_out = out_reg;

    always_comb begin
        pos = in_item.frame_start ? '0 : pos_reg;
        pos_next = pos[POS_W-1] ? pos : pos + 1'b1;
        date_off = pos - POS_DATE_FIRST;
        in_samples = pos inside {[POS_SAMPLE_FIRST:POS_SAMPLE_LAST]};
        k = 10'(pos[11:2] - 10'd2);
        is_low = in_samples && (pos[1:0] == LANE_LOW_BYTE);
        is_high = in_samples && (pos[1:0] == LANE_HIGH_BYTE)
                  && ({1'b0, k} < 11'(NUM_SAMPLES));

        raw = {in_item.data_byte, low_byte_reg};
        raw_sat = (raw > RAW_MAX) ? RAW_MAX[11:0] : raw[11:0];
        v = $signed({1'b0, raw_sat}) - CENTRE;
        clip_ext = 13'(cfg.clip_threshold);
        new_max = v > (in_item.frame_start ? 13'sd0 : max_level_reg);
        new_min = v < (in_item.frame_start ? 13'sd0 : min_level_reg);

        delta = $signed({1'b0, max_pos_reg}) - $signed({1'b0, cfg.pretrigger_samples});
        delta_ext = 26'(delta);
        us = {in_item.data_byte, count_reg};

        res = '0;
        emit = 1'b0;
        if (is_high) begin
            emit = 1'b1;
            res.kind = KIND_SAMPLE;
            res.data.sample_index = k;
            res.data.sample_value = (new_min && (v < clip_ext)) ? 13'sd0 : v;
        end else if (pos == POS_SUMMARY) begin
            emit = 1'b1;
            res.kind = KIND_SUMMARY;
            res.data.year = 12'({4'b0, date_reg[1]} + YEAR_BASE);
            res.data.month = date_reg[0];
            res.data.day = date_reg[3];
            res.data.hour = date_reg[2];
            res.data.minute = date_reg[5];
            res.data.second = date_reg[4];
            res.data.station_id = station_reg;
            res.data.microsecond = $signed({2'b0, us}) + (delta_ext <<< 3)
                                   + (delta_ext <<< 1);
            res.data.peak_index = max_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            low_byte_reg <= '0;
            max_level_reg <= '0;
            max_pos_reg <= '0;
            min_level_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                date_reg[i] <= '0;
            end
            station_reg <= '0;
            count_reg <= '0;
        end else if (work) begin
            pos_reg <= pos_next;
            if (in_item.frame_start) begin
                max_level_reg <= '0;
                max_pos_reg <= '0;
                min_level_reg <= '0;
            end
            if (!pos[POS_W-1]) begin
                if (pos == POS_STATION_LO) begin
                    station_reg <= 10'(in_item.data_byte[7:6]);
                end else if (pos == POS_STATION_HI) begin
                    station_reg <= {in_item.data_byte, station_reg[1:0]};
                end else if (is_low) begin
                    low_byte_reg <= in_item.data_byte;
                end else if (is_high) begin
                    if (new_max) begin
                        max_level_reg <= v;
                        max_pos_reg <= k;
                    end
                    if (new_min) begin
                        min_level_reg <= v;
                    end
                end else if (pos inside {[POS_DATE_FIRST:POS_DATE_LAST]}) begin
                    date_reg[date_off[2:0]] <= in_item.data_byte;
                end else if (pos == POS_COUNT_LO) begin
                    count_reg[7:0] <= in_item.data_byte;
                end else if (pos == POS_COUNT_MID) begin
                    count_reg[15:8] <= in_item.data_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (work && emit) begin
            out_reg <= res;
        end
    end

endmodule

// ===== verif/sensor_frame_peak_decoder_test.sv =====
// Self-checking testbench of the sensor frame peak decoder, predicting or listing every result.
`timescale 1ns / 100ps

module sensor_frame_peak_decoder_test;
    import sfpd_pkg::*;

    localparam int unsigned NUM_SAMPLES = 1020;
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned DIRECTED_ROWS = 28;

    typedef struct packed {
        logic [7:0]         data;
        logic               start;
        logic               typed;
        logic [9:0]         idx;
        logic signed [12:0] val;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_we;
    logic         cfg_addr;
    logic [11:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;

    // Predictor state and its copy of the registers.
    int unsigned        frame_pos;
    logic [7:0]         sample_lo;
    int                 peak_level;
    logic [9:0]         peak_pos;
    int                 floor_level;
    logic [7:0]         stamp_bytes [6];
    logic [9:0]         station_reg;
    logic [15:0]        count_lo;
    logic signed [11:0] clip_lvl;
    logic [9:0]         pretrig;

    sfpd_out_t   pending_results [$];
    dir_row_t    directed_rows [DIRECTED_ROWS];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          source_gaps;
    bit          sink_gaps;

    sensor_frame_peak_decoder #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic string result_text(sfpd_out_t r);
        return {$sformatf("kind=%0d idx=%0d val=%0d y=%0d m=%0d d=%0d ",
                          r.kind, r.data.sample_index, r.data.sample_value, r.data.year,
                          r.data.month, r.data.day),
                $sformatf("%0d:%0d:%0d stn=%0d us=%0d pk=%0d",
                          r.data.hour, r.data.minute, r.data.second,
                          r.data.station_id, r.data.microsecond, r.data.peak_index)};
    endfunction

    task automatic decode_frame_byte(input logic [7:0] b, input logic st, output bit got,
                                     output sfpd_out_t r);
        logic [1:0]  lane;
        int unsigned k;
        logic [15:0] raw;
        logic [23:0] us;
        int          v;
        int          o;
        int          micro;
        got = 1'b0;
        r = '0;
        if (st) begin
            frame_pos = 0;
            peak_level = 0;
            peak_pos = '0;
            floor_level = 0;
        end
        if (frame_pos < FRAME_BYTES) begin
            if (frame_pos == POS_STATION_LO) begin
                station_reg = {8'd0, b[7:6]};
            end else if (frame_pos == POS_STATION_HI) begin
                station_reg = {b, station_reg[1:0]};
            end else if (frame_pos >= POS_SAMPLE_FIRST && frame_pos <= POS_SAMPLE_LAST) begin
                lane = 2'(frame_pos - POS_SAMPLE_FIRST);
                k = (frame_pos - POS_SAMPLE_FIRST) >> 2;
                if (lane == LANE_LOW_BYTE) begin
                    sample_lo = b;
                end else if (lane == LANE_HIGH_BYTE && k < NUM_SAMPLES) begin
                    raw = {b, sample_lo};
                    if (raw > RAW_MAX) begin
                        raw = RAW_MAX;
                    end
                    v = int'(raw) - 2047;
                    o = v;
                    if (v > peak_level) begin
                        peak_level = v;
                        peak_pos = k[9:0];
                    end
                    if (v < floor_level) begin
                        floor_level = v;
                        if (v < int'(clip_lvl)) begin
                            o = 0;
                        end
                    end
                    r.kind = KIND_SAMPLE;
                    r.data.sample_index = k[9:0];
                    r.data.sample_value = o[12:0];
                    got = 1'b1;
                end
            end else if (frame_pos >= POS_DATE_FIRST && frame_pos <= POS_DATE_LAST) begin
                stamp_bytes[frame_pos - POS_DATE_FIRST] = b;
            end else if (frame_pos == POS_COUNT_LO) begin
                count_lo[7:0] = b;
            end else if (frame_pos == POS_COUNT_MID) begin
                count_lo[15:8] = b;
            end else if (frame_pos == POS_SUMMARY) begin
                us = {b, count_lo};
                micro = int'(us) + 10 * (int'(peak_pos) - int'(pretrig));
                r.kind = KIND_SUMMARY;
                r.data.year = 12'(stamp_bytes[1]) + YEAR_BASE;
                r.data.month = stamp_bytes[0];
                r.data.day = stamp_bytes[3];
                r.data.hour = stamp_bytes[2];
                r.data.minute = stamp_bytes[5];
                r.data.second = stamp_bytes[4];
                r.data.station_id = station_reg;
                r.data.microsecond = micro[25:0];
                r.data.peak_index = peak_pos;
                got = 1'b1;
            end
            frame_pos = frame_pos + 1;
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic st, input logic typed,
                             input sfpd_out_t typed_exp);
        bit        got;
        sfpd_out_t r;
        @(negedge aclk);
        if (source_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= st;
        do @(posedge aclk); while (!s_tready);
        decode_frame_byte(d, st, got, r);
        if (typed) begin
            pending_results = {pending_results, typed_exp};
        end else if (got) begin
            pending_results = {pending_results, r};
        end
    endtask

    task automatic send_frame(input int unsigned len, input logic mark);
        int unsigned mode;
        int unsigned peak_k;
        int unsigned p;
        logic [15:0] raw;
        logic [7:0]  hi;
        logic [7:0]  b;
        mode = $urandom_range(0, 3);
        peak_k = $urandom_range(0, 31);
        hi = '0;
        for (p = 0; p < len; p++) begin
            b = 8'($urandom_range(0, 255));
            if (p >= POS_SAMPLE_FIRST && p <= POS_SAMPLE_LAST) begin
                if (2'(p - POS_SAMPLE_FIRST) == LANE_LOW_BYTE) begin
                    case (mode)
                        0: raw = 16'($urandom_range(0, 4095));
                        1: raw = 16'($urandom_range(0, 2047));
                        2: raw = 16'($urandom_range(0, 65535));
                        default: begin
                            if ((p - POS_SAMPLE_FIRST) / 4 == peak_k) begin
                                raw = 16'($urandom_range(2048, 4095));
                            end else begin
                                raw = 16'($urandom_range(1900, 2047));
                            end
                        end
                    endcase
                    if ($urandom_range(0, 31) == 0) begin
                        raw = $urandom_range(0, 1) ? RAW_MAX : 16'd0;
                    end
                    b = raw[7:0];
                    hi = raw[15:8];
                end else if (2'(p - POS_SAMPLE_FIRST) == LANE_HIGH_BYTE) begin
                    b = hi;
                end
            end
            send_byte(b, mark && p == 0, 1'b0, '0);
        end
    endtask

    task automatic random_phase();
        repeat (3) begin
            send_frame($urandom_range(80, 140), $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [11:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (addr == CFG_CLIP_THRESHOLD) begin
            clip_lvl = value;
        end else begin
            pretrig = value[9:0];
        end
    endtask

    initial begin : stimulus
        sfpd_out_t typed_exp;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_CLIP_THRESHOLD;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        frame_pos = 0;
        sample_lo = '0;
        peak_level = 0;
        peak_pos = '0;
        floor_level = 0;
        foreach (stamp_bytes[i]) stamp_bytes[i] = '0;
        station_reg = '0;
        count_lo = '0;
        clip_lvl = CLIP_RESET;
        pretrig = PRETRIGGER_RESET;
        source_gaps = 1'b1;
        sink_gaps = 1'b1;
        // The first frame runs without a mark, then a marked frame cuts in.
        directed_rows = '{
            '{8'h11, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h22, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h33, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h44, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hC0, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hFF, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hFF, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hFF, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hFF, 1'b0, 1'b1, 10'd0, 13'sd2048},
            '{8'hA5, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h5A, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b1, 10'd1, 13'sd0},
            '{8'hFF, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'hFF, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b1, 10'd2, -13'sd2047},
            '{8'h00, 1'b1, 1'b0, 10'd0, 13'sd0},
            '{8'h01, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h02, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h03, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h40, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h00, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h06, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h07, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h01, 1'b0, 1'b0, 10'd0, 13'sd0},
            '{8'h08, 1'b0, 1'b0, 10'd0, 13'sd0}
        };
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            typed_exp = '0;
            typed_exp.kind = KIND_SAMPLE;
            typed_exp.data.sample_index = directed_rows[i].idx;
            typed_exp.data.sample_value = directed_rows[i].val;
            send_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].typed,
                      typed_exp);
        end
        random_phase();
        settle();
        write_reg(CFG_CLIP_THRESHOLD, -12'sd2047);
        write_reg(CFG_PRETRIGGER, 12'd0);
        random_phase();
        settle();
        write_reg(CFG_CLIP_THRESHOLD, 12'd0);
        write_reg(CFG_PRETRIGGER, 12'd1023);
        random_phase();
        settle();
        source_gaps = 1'b0;
        sink_gaps = 1'b0;
        write_reg(CFG_CLIP_THRESHOLD, 12'($urandom_range(0, 4095)));
        write_reg(CFG_PRETRIGGER, 12'($urandom_range(0, 4095)));
        random_phase();
        settle();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : sink
        int unsigned stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        sfpd_out_t got;
        sfpd_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.data = m_tdata;
            got.data.pad = '0;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: %s", result_text(got));
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected %s", result_text(want));
                        $display("          actual   %s", result_text(got));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sensor_frame_peak_decoder.f =====
design/sfpd_pkg.sv
design/sfpd_in_reg.sv
design/sfpd_decode.sv
design/sensor_frame_peak_decoder.sv
verif/sensor_frame_peak_decoder_test.sv
